// ===== sv/mcrc_pkg.sv =====
// shared constants, types and helpers for the cascaded rc low-pass unit
`timescale 1ns / 1ps
`default_nettype none
package mcrc_pkg;

    localparam int CHANNELS    = 16;
    localparam int CH_W        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int FRAC_BITS   = 9;
    localparam int SAMPLE_BITS = 16;
    localparam int ST_W        = SAMPLE_BITS + FRAC_BITS + 1;
    localparam int OUT_W       = 16;
    localparam int CNT_W       = 5;
    localparam int CHAN_IN_W   = 8;
    localparam int TAU_IN_W    = 10;
    localparam int TAU_W       = 9;
    localparam int TAU_MIN     = 1;
    localparam int TAU_MAX     = 511;
    localparam int OUT_MAX     = 32767;
    localparam int OUT_MIN     = -32768;
    localparam int PROD_W      = ST_W + 1 + TAU_W + 1;
    localparam int MEM_W       = SAMPLE_BITS + 3 * ST_W;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_BAD = 1'b1;
    localparam logic FUNC_PUSH  = 1'b0;
    localparam logic FUNC_READ  = 1'b1;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] raw;
        logic signed [ST_W-1:0]        s1;
        logic signed [ST_W-1:0]        s2;
        logic signed [ST_W-1:0]        s3;
    } t_entry;

    function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [31:0] v);
        logic signed [31:0] w;
        begin
            w = v;
            if (w > OUT_MAX) begin
                w = OUT_MAX;
            end else if (w < OUT_MIN) begin
                w = OUT_MIN;
            end
            return w[OUT_W-1:0];
        end
    endfunction

endpackage
`default_nettype wire

// ===== sv/multichannel_cascaded_rc_lowpass_unit.sv =====
// top level of the multichannel three-stage cascaded rc low-pass unit
`timescale 1ns / 1ps
`default_nettype none
// Each transfer addresses one channel whose raw sample and three Q9 stage values live
// in one ram entry. A push reads the entry, runs the three stages in order through one
// shared multiplier (a multiply state and an add state per stage), writes the entry back
// and presents the result. A push passes ST_READ, the three multiply and add pairs and
// ST_DONE; a read passes ST_READ and ST_DONE, and a rejected channel goes straight to
// ST_DONE. Entries never written read as zero through per-channel valid flops, so no
// clearing pass follows reset. The input side waits only while an item is at work,
// which includes holding a finished result until the output register is free.
module multichannel_cascaded_rc_lowpass_unit
    import mcrc_pkg::*;
(
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [CNT_W-1:0]              i_cfg_data,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic                          i_func,
    input  wire logic [CHAN_IN_W-1:0]          i_channel,
    input  wire logic signed [SAMPLE_BITS-1:0] i_sample,
    input  wire logic [TAU_IN_W-1:0]           i_tau,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic                               o_status,
    output logic signed [OUT_W-1:0]            o_raw_out,
    output logic signed [OUT_W-1:0]            o_first_out,
    output logic signed [OUT_W-1:0]            o_second_out,
    output logic signed [OUT_W-1:0]            o_third_out
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_MUL,
        ST_ADD,
        ST_DONE
    } t_state;

    t_state                  r_state;
    logic [CNT_W-1:0]        r_count;
    logic [CHANNELS-1:0]     r_vld;
    logic                    r_rd_vld;
    logic [CH_W-1:0]         r_ch;
    logic                    r_func;
    logic                    r_ok;
    logic [TAU_W-1:0]        r_tau;
    logic [1:0]              r_stg;
    logic signed [SAMPLE_BITS-1:0] r_raw;
    logic signed [ST_W-1:0]  r_s1;
    logic signed [ST_W-1:0]  r_s2;
    logic signed [ST_W-1:0]  r_s3;
    logic signed [PROD_W-1:0] r_prod;
    logic                    r_ovalid;
    logic                    r_status;
    logic signed [OUT_W-1:0] r_raw_out;
    logic signed [OUT_W-1:0] r_first_out;
    logic signed [OUT_W-1:0] r_second_out;
    logic signed [OUT_W-1:0] r_third_out;

    logic                    w_accept;
    logic                    w_ok;
    logic [TAU_W-1:0]        w_tau;
    logic                    w_out_free;
    logic                    w_we;
    t_entry                  w_rd;
    t_entry                  w_wr;
    logic [MEM_W-1:0]        w_rdata;
    logic signed [ST_W-1:0]  w_scaled;
    logic signed [ST_W-1:0]  w_prev;
    logic signed [ST_W-1:0]  w_cur;
    logic signed [ST_W:0]    w_diff;
    logic signed [PROD_W-1:0] w_step;
    logic signed [ST_W-1:0]  w_new;

    assign o_ready    = (r_state == ST_IDLE);
    assign w_accept   = i_valid && o_ready;
    assign w_out_free = !r_ovalid || i_ready;
    assign w_ok       = (9'(i_channel) < 9'(r_count)) && (9'(i_channel) < 9'(CHANNELS));
    assign w_we       = (r_state == ST_DONE) && w_out_free && r_ok && (r_func == FUNC_PUSH);

    always_comb begin
        if (i_tau < TAU_IN_W'(TAU_MIN)) begin
            w_tau = TAU_W'(TAU_MIN);
        end else if (i_tau > TAU_IN_W'(TAU_MAX)) begin
            w_tau = TAU_W'(TAU_MAX);
        end else begin
            w_tau = i_tau[TAU_W-1:0];
        end
    end

    assign w_rd = t_entry'(w_rdata);
    assign w_wr = '{raw: r_raw, s1: r_s1, s2: r_s2, s3: r_s3};

    mcrc_ram #(
        .WIDTH (MEM_W),
        .DEPTH (CHANNELS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_ch),
        .i_wdata (w_wr),
        .i_raddr (i_channel[CH_W-1:0]),
        .o_rdata (w_rdata)
    );

    // stage operand select for the shared multiplier
    assign w_scaled = {{(ST_W-SAMPLE_BITS-FRAC_BITS){r_raw[SAMPLE_BITS-1]}}, r_raw,
                       {FRAC_BITS{1'b0}}};

    always_comb begin
        case (r_stg)
            2'd0: begin
                w_prev = w_scaled;
                w_cur  = r_s1;
            end
            2'd1: begin
                w_prev = r_s1;
                w_cur  = r_s2;
            end
            default: begin
                w_prev = r_s2;
                w_cur  = r_s3;
            end
        endcase
    end

    assign w_diff = {w_prev[ST_W-1], w_prev} - {w_cur[ST_W-1], w_cur};
    assign w_step = r_prod >>> FRAC_BITS;
    assign w_new  = w_cur + w_step[ST_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_vld    <= '0;
            r_ovalid <= 1'b0;
            r_stg    <= '0;
        end else begin
            if (i_cfg_we) begin
                r_count <= i_cfg_data;
            end
            if (r_ovalid && i_ready && (r_state != ST_DONE)) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_ch     <= i_channel[CH_W-1:0];
                        r_func   <= i_func;
                        r_ok     <= w_ok;
                        r_tau    <= w_tau;
                        r_raw    <= i_sample;
                        r_rd_vld <= r_vld[i_channel[CH_W-1:0]];
                        r_stg    <= '0;
                        r_state  <= w_ok ? ST_READ : ST_DONE;
                    end
                end
                ST_READ: begin
                    if (r_rd_vld) begin
                        r_s1 <= w_rd.s1;
                        r_s2 <= w_rd.s2;
                        r_s3 <= w_rd.s3;
                    end else begin
                        r_s1 <= '0;
                        r_s2 <= '0;
                        r_s3 <= '0;
                    end
                    if (r_func == FUNC_PUSH) begin
                        r_state <= ST_MUL;
                    end else begin
                        r_raw   <= r_rd_vld ? w_rd.raw : '0;
                        r_state <= ST_DONE;
                    end
                end
                ST_MUL: begin
                    r_prod  <= w_diff * $signed({1'b0, r_tau});
                    r_state <= ST_ADD;
                end
                ST_ADD: begin
                    case (r_stg)
                        2'd0:    r_s1 <= w_new;
                        2'd1:    r_s2 <= w_new;
                        default: r_s3 <= w_new;
                    endcase
                    if (r_stg == 2'd2) begin
                        r_state <= ST_DONE;
                    end else begin
                        r_stg   <= r_stg + 2'd1;
                        r_state <= ST_MUL;
                    end
                end
                ST_DONE: begin
                    if (w_out_free) begin
                        r_ovalid <= 1'b1;
                        if (r_ok) begin
                            r_status     <= STATUS_OK;
                            r_raw_out    <= sat_out(32'(r_raw));
                            r_first_out  <= sat_out(32'($signed(r_s1[ST_W-1:FRAC_BITS])));
                            r_second_out <= sat_out(32'($signed(r_s2[ST_W-1:FRAC_BITS])));
                            r_third_out  <= sat_out(32'($signed(r_s3[ST_W-1:FRAC_BITS])));
                        end else begin
                            r_status     <= STATUS_BAD;
                            r_raw_out    <= '0;
                            r_first_out  <= '0;
                            r_second_out <= '0;
                            r_third_out  <= '0;
                        end
                        if (w_we) begin
                            r_vld[r_ch] <= 1'b1;
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_valid      = r_ovalid;
    assign o_status     = r_status;
    assign o_raw_out    = r_raw_out;
    assign o_first_out  = r_first_out;
    assign o_second_out = r_second_out;
    assign o_third_out  = r_third_out;

endmodule
`default_nettype wire

// ===== sv/mcrc_ram.sv =====
// generic single-port-write ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module mcrc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_we,
    input  wire logic [AW-1:0]           i_waddr,
    input  wire logic [WIDTH-1:0]        i_wdata,
    input  wire logic [AW-1:0]           i_raddr,
    output logic      [WIDTH-1:0]        o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire
